// ===== rtl/core/imr_pkg.sv =====
// shared types, constants and field codes of the icmp reply matcher
`timescale 1ns / 1ps

package imr_pkg;

   localparam int MaxPacket   = 1024;
   localparam int CountWidth  = $clog2(MaxPacket + 1);
   localparam int SumWidth    = (CountWidth > 8) ? CountWidth : 8;
   localparam int HdrLenWidth = 6;

   localparam int CsrIndexWidth = 8;
   localparam int CsrDataWidth  = 16;

   localparam logic [CsrIndexWidth-1:0] CsrProbeIdent = CsrIndexWidth'(0);
   localparam logic [CsrIndexWidth-1:0] CsrProbeSeq   = CsrIndexWidth'(1);

   localparam logic [SumWidth-1:0] MinHdrLen     = SumWidth'(20);
   localparam logic [SumWidth-1:0] IcmpHdrLen    = SumWidth'(8);
   localparam logic [SumWidth-1:0] ProtoOffset   = SumWidth'(9);
   localparam logic [SumWidth-1:0] IdOffset      = SumWidth'(4);
   localparam logic [SumWidth-1:0] SeqOffset     = SumWidth'(6);
   localparam logic [SumWidth-1:0] SrcAddrFirst  = SumWidth'(12);
   localparam logic [SumWidth-1:0] SrcAddrLast   = SumWidth'(15);

   localparam logic [7:0] TypeEchoReply    = 8'd0;
   localparam logic [7:0] TypeUnreachable  = 8'd3;
   localparam logic [7:0] TypeTimeExceeded = 8'd11;
   localparam logic [7:0] ProtoIcmp        = 8'd1;

   localparam logic [2:0] VerdictMalformed    = 3'd0;
   localparam logic [2:0] VerdictOtherType    = 3'd1;
   localparam logic [2:0] VerdictNotOurs      = 3'd2;
   localparam logic [2:0] VerdictEchoReply    = 3'd3;
   localparam logic [2:0] VerdictTimeExceeded = 3'd4;
   localparam logic [2:0] VerdictUnreachable  = 3'd5;

   typedef struct packed {
      logic [CountWidth-1:0]  count;
      logic [HdrLenWidth-1:0] outer_hdr_len;
      logic [7:0]             msg_type;
      logic [7:0]             msg_code;
      logic [15:0]            reply_id;
      logic [15:0]            reply_seq;
      logic [HdrLenWidth-1:0] quoted_hdr_len;
      logic [7:0]             quoted_proto;
      logic [15:0]            quoted_id;
      logic [15:0]            quoted_seq;
      logic [31:0]            source_addr;
   } imr_packet_type;

   typedef struct packed {
      logic [31:0] reporter_addr;
      logic [7:0]  icmp_code;
      logic        ends_path;
      logic [2:0]  verdict;
   } imr_result_type;

   localparam int ResultWidth  = $bits(imr_result_type);
   localparam int RspDataWidth = ((ResultWidth + 7) / 8) * 8;

endpackage

// ===== rtl/core/icmp_reply_matcher.sv =====
// path: a last byte passes the input register, then the snapshot, then the output register that holds the result
// throughput: one byte per cycle while the input is not stalled, results buffered in a snapshot and an output register
// stall: input stalls only when a last byte meets a full snapshot and output register
// reset: synchronous, clears probe registers, capture state and all valid flags
// top level of the icmp reply matcher
`timescale 1ns / 1ps

module icmp_reply_matcher import imr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // data_byte
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RspDataWidth-1:0]  rsp_tdata,   // verdict, ends_path, icmp_code, reporter_addr
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   logic [15:0]    probe_ident_ff, probe_ident_in;
   logic [15:0]    probe_seq_ff, probe_seq_in;
   logic           snap_valid, snap_ready;
   imr_packet_type snap;

   assign csr_ready = 1'b1;

   always_comb begin
      probe_ident_in = probe_ident_ff;
      probe_seq_in   = probe_seq_ff;
      if (csr_valid) begin
         case (csr_index)
            CsrProbeIdent: probe_ident_in = csr_data[15:0];
            CsrProbeSeq:   probe_seq_in   = csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ident_ff <= '0;
         probe_seq_ff   <= '0;
      end else begin
         probe_ident_ff <= probe_ident_in;
         probe_seq_ff   <= probe_seq_in;
      end
   end

   imr_capture u_capture (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap)
   );

   imr_judge u_judge (
      .clock       (clock),
      .reset       (reset),
      .snap_valid  (snap_valid),
      .snap_ready  (snap_ready),
      .snap        (snap),
      .probe_ident (probe_ident_ff),
      .probe_seq   (probe_seq_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// ===== rtl/core/imr_capture.sv =====
// input register and per-byte field capture, snapshot of a finished packet
`timescale 1ns / 1ps

module imr_capture import imr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [7:0]     req_tdata,
   input  logic           req_tlast,
   output logic           snap_valid,
   input  logic           snap_ready,
   output imr_packet_type snap
);

   logic           s1_valid_ff, s1_valid_in;
   logic [7:0]     s1_byte_ff;
   logic           s1_last_ff;
   imr_packet_type pkt_ff, pkt_in, pkt_next;
   logic           snap_valid_ff, snap_valid_in;
   imr_packet_type snap_ff;
   logic           snap_free, s1_fire, req_fire;
   logic [SumWidth-1:0] pos, ihl, q, qb;

   assign snap_free  = !snap_valid_ff || snap_ready;
   assign s1_fire    = s1_valid_ff && (!s1_last_ff || snap_free);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;
   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

   // field capture at fixed and header-relative offsets
   always_comb begin
      pkt_next = pkt_ff;
      pos      = SumWidth'(pkt_ff.count);
      ihl      = '0;
      q        = '0;
      qb       = '0;
      if (pkt_ff.count < CountWidth'(MaxPacket)) begin
         pkt_next.count = pkt_ff.count + CountWidth'(1);
         if (pos == '0) begin
            pkt_next.outer_hdr_len = {s1_byte_ff[3:0], 2'b00};
         end
         if (pos >= SrcAddrFirst && pos <= SrcAddrLast) begin
            pkt_next.source_addr = {pkt_ff.source_addr[23:0], s1_byte_ff};
         end
         ihl = SumWidth'(pkt_next.outer_hdr_len);
         if (pos == ihl) begin
            pkt_next.msg_type = s1_byte_ff;
         end
         if (pos == ihl + SumWidth'(1)) begin
            pkt_next.msg_code = s1_byte_ff;
         end
         if (pos == ihl + IdOffset) begin
            pkt_next.reply_id[15:8] = s1_byte_ff;
         end
         if (pos == ihl + IdOffset + SumWidth'(1)) begin
            pkt_next.reply_id[7:0] = s1_byte_ff;
         end
         if (pos == ihl + SeqOffset) begin
            pkt_next.reply_seq[15:8] = s1_byte_ff;
         end
         if (pos == ihl + SeqOffset + SumWidth'(1)) begin
            pkt_next.reply_seq[7:0] = s1_byte_ff;
         end
         q = ihl + IcmpHdrLen;
         if (pos == q) begin
            pkt_next.quoted_hdr_len = {s1_byte_ff[3:0], 2'b00};
         end
         if (pos == q + ProtoOffset) begin
            pkt_next.quoted_proto = s1_byte_ff;
         end
         qb = q + SumWidth'(pkt_ff.quoted_hdr_len);
         if (pos == qb + IdOffset) begin
            pkt_next.quoted_id[15:8] = s1_byte_ff;
         end
         if (pos == qb + IdOffset + SumWidth'(1)) begin
            pkt_next.quoted_id[7:0] = s1_byte_ff;
         end
         if (pos == qb + SeqOffset) begin
            pkt_next.quoted_seq[15:8] = s1_byte_ff;
         end
         if (pos == qb + SeqOffset + SumWidth'(1)) begin
            pkt_next.quoted_seq[7:0] = s1_byte_ff;
         end
      end
   end

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      pkt_in        = pkt_ff;
      snap_valid_in = snap_valid_ff;
      if (snap_valid_ff && snap_ready) begin
         snap_valid_in = 1'b0;
      end
      if (s1_fire) begin
         s1_valid_in = 1'b0;
         if (s1_last_ff) begin
            pkt_in        = '0;
            snap_valid_in = 1'b1;
         end else begin
            pkt_in = pkt_next;
         end
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         pkt_ff        <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         pkt_ff        <= pkt_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      if (s1_fire && s1_last_ff) begin
         snap_ff <= pkt_next;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      pkt_ff.count <= CountWidth'(MaxPacket))
      else $error("byte count beyond packet limit");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_last_ff |=> pkt_ff.count == '0)
      else $error("capture state not cleared after last byte");

   a_snap_nonempty: assert property (@(posedge clock) disable iff (reset)
      snap_valid_ff |-> snap_ff.count != '0)
      else $error("snapshot of an empty packet");

endmodule

// ===== rtl/core/imr_judge.sv =====
// length, type and probe match checks on a packet snapshot, verdict into the result register
`timescale 1ns / 1ps

module imr_judge import imr_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    snap_valid,
   output logic                    snap_ready,
   input  imr_packet_type          snap,
   input  logic [15:0]             probe_ident,
   input  logic [15:0]             probe_seq,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata
);

   logic           rsp_valid_ff, rsp_valid_in;
   imr_result_type rsp_ff, result;
   logic [2:0]     verdict;
   logic [SumWidth-1:0] n, ihl, qihl;
   logic           snap_fire;

   assign snap_ready = !rsp_valid_ff || rsp_tready;
   assign snap_fire  = snap_valid && snap_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RspDataWidth'(rsp_ff);

   always_comb begin
      n       = SumWidth'(snap.count);
      ihl     = SumWidth'(snap.outer_hdr_len);
      qihl    = SumWidth'(snap.quoted_hdr_len);
      verdict = VerdictOtherType;
      if (ihl < MinHdrLen || n < ihl + IcmpHdrLen) begin
         verdict = VerdictMalformed;
      end else if (snap.msg_type == TypeEchoReply) begin
         if (snap.reply_id != probe_ident || snap.reply_seq != probe_seq) begin
            verdict = VerdictNotOurs;
         end else begin
            verdict = VerdictEchoReply;
         end
      end else if (snap.msg_type == TypeTimeExceeded || snap.msg_type == TypeUnreachable) begin
         if (n < ihl + IcmpHdrLen + MinHdrLen || qihl < MinHdrLen
             || n < ihl + IcmpHdrLen + qihl + IcmpHdrLen) begin
            verdict = VerdictMalformed;
         end else if (snap.quoted_proto != ProtoIcmp) begin
            verdict = VerdictNotOurs;
         end else if (snap.quoted_id != probe_ident || snap.quoted_seq != probe_seq) begin
            verdict = VerdictNotOurs;
         end else if (snap.msg_type == TypeUnreachable) begin
            verdict = VerdictUnreachable;
         end else begin
            verdict = VerdictTimeExceeded;
         end
      end
      result.verdict       = verdict;
      result.ends_path     = (verdict == VerdictEchoReply) || (verdict == VerdictUnreachable);
      result.icmp_code     = snap.msg_code;
      result.reporter_addr = snap.source_addr;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (snap_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_fire) begin
         rsp_ff <= result;
      end
   end

   a_verdict_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.verdict <= VerdictUnreachable)
      else $error("verdict code out of range");

   a_ends_path: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.ends_path ==
         (rsp_ff.verdict == VerdictEchoReply || rsp_ff.verdict == VerdictUnreachable))
      else $error("path end flag disagrees with verdict");

   a_snap_to_rsp: assert property (@(posedge clock) disable iff (reset)
      snap_fire |=> rsp_valid_ff)
      else $error("snapshot taken but no result registered");

endmodule
